@@ rtl/vector3_alu_macros.svh @@
// Assertion macros shared by the vector3_alu checker.
`ifndef VECTOR3_ALU_MACROS_SVH
`define VECTOR3_ALU_MACROS_SVH

// Check outside reset.
`define V3A_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define V3A_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/v3a_pkg.sv @@
// Shared types and constants of the vector3_alu pipeline.
package v3a_pkg;

    localparam int OP_BITS = 4;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SCALE = 4'd2,
        OP_DIV   = 4'd3,
        OP_DOT   = 4'd4,
        OP_CROSS = 4'd5,
        OP_NORM  = 4'd6,
        OP_MAG   = 4'd7,
        OP_DIST  = 4'd8
    } op_t;

    typedef struct packed {
        logic fault;
        logic use_div;
        logic use_root;
        logic den_s;
    } v3a_ctrl_t;

    localparam int CTRL_BITS = $bits(v3a_ctrl_t);

endpackage

@@ rtl/vector3_alu.sv @@
// Top level of the fixed-point three-component vector unit.
//
// Operands and results are Q16.16 with the default parameters. Takes one item per
// cycle while s_tready is high and returns one result item per input item, in order.
// The pipeline holds five front stages, a square root that retires one root bit per
// stage over WORD_BITS stages, a three-lane divider that retires one quotient bit per
// stage over WORD_BITS + FRAC_BITS stages, and the output register. Every stage has
// its own valid bit and a stalled output only holds the stages that are full, so
// empty stages keep filling.
module vector3_alu
    import v3a_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // ax, ay, az, bx, by, bz, scalar_in
    input  logic [((7*WORD_BITS+7)/8)*8-1:0]       s_tdata,
    // operation
    input  logic [OP_BITS-1:0]                     s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // rx, ry, rz, scalar_out
    output logic [((4*WORD_BITS+7)/8)*8-1:0]       m_tdata,
    // fault
    output logic                                   m_tuser
);

    localparam int W        = WORD_BITS;
    localparam int NB       = WORD_BITS + FRAC_BITS;
    localparam int OUT_DATA = ((4*WORD_BITS+7)/8)*8;
    localparam int NS       = 5 + W + NB + 1;
    localparam int SQ_SIDE  = CTRL_BITS + 8*W + 3;
    localparam int DV_SIDE  = CTRL_BITS + 5*W + 3;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] vld_in;
    logic [NS-1:0] adv;

    for (genvar k = 0; k < NS; k++)
    begin : g_adv
        assign adv[k] = m_tready | ~(&vld_reg[NS-1:k]);
    end

    assign vld_in = {vld_reg[NS-2:0], s_tvalid};

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            vld_next[k] = adv[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NS-1];

    logic [2:0][W-1:0] a_in;
    logic [2:0][W-1:0] b_in;

    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign a_in[i] = s_tdata[i*W +: W];
        assign b_in[i] = s_tdata[(i+3)*W +: W];
    end

    v3a_ctrl_t         fr_ctrl;
    logic [3:0][W-1:0] fr_word;
    logic [2:0][W-1:0] fr_num;
    logic [2:0]        fr_qneg;
    logic [W-1:0]      fr_sden;
    logic [2*W-1:0]    fr_rad;

    v3a_front #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_front
    (
        .clk      (clk),
        .en       (adv[4:0]),
        .op_in    (s_tuser),
        .a_in     (a_in),
        .b_in     (b_in),
        .s_in     (s_tdata[6*W +: W]),
        .ctrl_out (fr_ctrl),
        .word_out (fr_word),
        .num_out  (fr_num),
        .qneg_out (fr_qneg),
        .sden_out (fr_sden),
        .rad_out  (fr_rad)
    );

    logic [2*W-1:0]     sq_rad  [W+1];
    logic [W+1:0]       sq_rem  [W+1];
    logic [W-1:0]       sq_root [W+1];
    logic [SQ_SIDE-1:0] sq_side [W+1];

    assign sq_rad[0]  = fr_rad;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {fr_ctrl, fr_word, fr_num, fr_qneg, fr_sden};

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        v3a_sqrt_step #(.WORD_BITS(W), .SIDE_BITS(SQ_SIDE)) u_step
        (
            .clk      (clk),
            .en       (adv[5+k]),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .side_in  (sq_side[k]),
            .rad_out  (sq_rad[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .side_out (sq_side[k+1])
        );
    end

    v3a_ctrl_t         sq_ctrl;
    logic [3:0][W-1:0] sq_word;
    logic [2:0][W-1:0] sq_num;
    logic [2:0]        sq_qneg;
    logic [W-1:0]      sq_sden;

    assign {sq_ctrl, sq_word, sq_num, sq_qneg, sq_sden} = sq_side[W];

    logic [W-1:0]          dv_den  [NB+1];
    logic [2:0][NB-1:0]    dv_num  [NB+1];
    logic [2:0][W-1:0]     dv_rem  [NB+1];
    logic [2:0][NB-1:0]    dv_quo  [NB+1];
    logic [DV_SIDE-1:0]    dv_side [NB+1];

    assign dv_den[0]  = sq_ctrl.den_s ? sq_sden : sq_root[W];
    assign dv_rem[0]  = '0;
    assign dv_quo[0]  = '0;
    assign dv_side[0] = {sq_ctrl, sq_word, sq_qneg, sq_root[W]};

    for (genvar i = 0; i < 3; i++)
    begin : g_num
        assign dv_num[0][i] = {sq_num[i], {FRAC_BITS{1'b0}}};
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_div
        v3a_div_step #(.WORD_BITS(W), .NUM_BITS(NB), .SIDE_BITS(DV_SIDE)) u_step
        (
            .clk      (clk),
            .en       (adv[5+W+k]),
            .den_in   (dv_den[k]),
            .num_in   (dv_num[k]),
            .rem_in   (dv_rem[k]),
            .quo_in   (dv_quo[k]),
            .side_in  (dv_side[k]),
            .den_out  (dv_den[k+1]),
            .num_out  (dv_num[k+1]),
            .rem_out  (dv_rem[k+1]),
            .quo_out  (dv_quo[k+1]),
            .side_out (dv_side[k+1])
        );
    end

    v3a_ctrl_t         fn_ctrl;
    logic [3:0][W-1:0] fn_word;
    logic [2:0]        fn_qneg;
    logic [W-1:0]      fn_root;
    logic [2:0][W-1:0] qw;
    logic [2:0]        qovf;
    logic [W-1:0]      rw;
    logic              rovf;
    logic [3:0][W-1:0] res_c;
    logic              fault_c;
    logic [3:0][W-1:0] res_reg;
    logic              fault_reg;

    assign {fn_ctrl, fn_word, fn_qneg, fn_root} = dv_side[NB];

    for (genvar i = 0; i < 3; i++)
    begin : g_qsat
        v3a_sat #(.WORD_BITS(W), .MAG_BITS(NB)) u_sat
        (
            .neg  (fn_qneg[i]),
            .mag  (dv_quo[NB][i]),
            .word (qw[i]),
            .ovf  (qovf[i])
        );
    end

    v3a_sat #(.WORD_BITS(W), .MAG_BITS(W)) u_rsat
    (
        .neg  (1'b0),
        .mag  (fn_root),
        .word (rw),
        .ovf  (rovf)
    );

    always_comb
    begin
        res_c   = fn_word;
        fault_c = fn_ctrl.fault;
        if (fn_ctrl.use_div)
        begin
            res_c[2:0] = qw;
            fault_c    = fault_c | (|qovf);
        end
        if (fn_ctrl.use_root)
        begin
            res_c[3] = rw;
            fault_c  = fault_c | rovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            res_reg   <= res_c;
            fault_reg <= fault_c;
        end
    end

    assign m_tdata = OUT_DATA'(res_reg);
    assign m_tuser = fault_reg;

endmodule

@@ rtl/v3a_sat.sv @@
// Sign-magnitude to two's complement word with saturation.
module v3a_sat
#(
    parameter int WORD_BITS = 32,
    parameter int MAG_BITS  = 32
)
(
    input  logic                 neg,
    input  logic [MAG_BITS-1:0]  mag,
    output logic [WORD_BITS-1:0] word,
    output logic                 ovf
);

    localparam logic [MAG_BITS-1:0] POS_LIM =
        MAG_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic [MAG_BITS-1:0] NEG_LIM = POS_LIM + 1'b1;

    logic [MAG_BITS-1:0]  lim;
    logic [WORD_BITS-1:0] m;

    always_comb
    begin
        lim  = neg ? NEG_LIM : POS_LIM;
        ovf  = mag > lim;
        m    = ovf ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        word = neg ? (~m + 1'b1) : m;
    end

endmodule

@@ rtl/v3a_front.sv @@
// Front stages: operand select, multiply, combine, magnitude and early results.
module v3a_front
    import v3a_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic [4:0]                    en,
    input  logic [OP_BITS-1:0]            op_in,
    input  logic [2:0][WORD_BITS-1:0]     a_in,
    input  logic [2:0][WORD_BITS-1:0]     b_in,
    input  logic [WORD_BITS-1:0]          s_in,
    output v3a_ctrl_t                     ctrl_out,
    output logic [3:0][WORD_BITS-1:0]     word_out,
    output logic [2:0][WORD_BITS-1:0]     num_out,
    output logic [2:0]                    qneg_out,
    output logic [WORD_BITS-1:0]          sden_out,
    output logic [2*WORD_BITS-1:0]        rad_out
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int CW = 2 * WORD_BITS + 2;
    localparam logic [W-1:0] WMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]   DMIN  = {2'b11, {(W-1){1'b0}}};

    // stage 1
    op_t               op_c;
    logic [2:0][W:0]   d_c;
    logic [2:0][W:0]   as_c;
    logic              big_c;
    logic [5:0][W-1:0] x_c;
    logic [5:0][W-1:0] y_c;

    op_t               op1_reg;
    logic [5:0][W-1:0] x1_reg;
    logic [5:0][W-1:0] y1_reg;
    logic [2:0][W:0]   as1_reg;
    logic              big1_reg;
    logic [2:0][W-1:0] a1_reg;
    logic [W-1:0]      s1_reg;

    always_comb
    begin
        op_c  = op_t'(op_in);
        big_c = 1'b0;
        x_c   = '0;
        y_c   = '0;
        for (int i = 0; i < 3; i++)
        begin
            d_c[i]  = {a_in[i][W-1], a_in[i]} - {b_in[i][W-1], b_in[i]};
            as_c[i] = (op_c == OP_SUB) ? d_c[i] : ({a_in[i][W-1], a_in[i]} + {b_in[i][W-1], b_in[i]});
            big_c   = big_c | (d_c[i][W] ^ d_c[i][W-1]) | (d_c[i] == DMIN);
        end
        unique case (op_c) inside
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    x_c[i] = a_in[i];
                    y_c[i] = s_in;
                end
            end
            OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    x_c[i] = a_in[i];
                    y_c[i] = b_in[i];
                end
            end
            OP_CROSS:
            begin
                x_c[0] = a_in[1]; y_c[0] = b_in[2];
                x_c[1] = a_in[2]; y_c[1] = b_in[0];
                x_c[2] = a_in[0]; y_c[2] = b_in[1];
                x_c[3] = a_in[2]; y_c[3] = b_in[1];
                x_c[4] = a_in[0]; y_c[4] = b_in[2];
                x_c[5] = a_in[1]; y_c[5] = b_in[0];
            end
            OP_NORM, OP_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    x_c[i] = a_in[i];
                    y_c[i] = a_in[i];
                end
            end
            OP_DIST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    x_c[i] = d_c[i][W-1:0];
                    y_c[i] = d_c[i][W-1:0];
                end
            end
            default:
            begin
                x_c = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            op1_reg  <= op_c;
            x1_reg   <= x_c;
            y1_reg   <= y_c;
            as1_reg  <= as_c;
            big1_reg <= big_c;
            a1_reg   <= a_in;
            s1_reg   <= s_in;
        end
    end

    // stage 2
    logic [PW-1:0]     p_c [6];
    op_t               op2_reg;
    logic [PW-1:0]     p2_reg [6];
    logic [2:0][W:0]   as2_reg;
    logic              big2_reg;
    logic [2:0][W-1:0] a2_reg;
    logic [W-1:0]      s2_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            p_c[i] = $signed(x1_reg[i]) * $signed(y1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            op2_reg  <= op1_reg;
            p2_reg   <= p_c;
            as2_reg  <= as1_reg;
            big2_reg <= big1_reg;
            a2_reg   <= a1_reg;
            s2_reg   <= s1_reg;
        end
    end

    // stage 3
    logic [CW-1:0]     e_c [6];
    logic [2:0][CW-1:0] c_c;
    op_t               op3_reg;
    logic [2:0][CW-1:0] c3_reg;
    logic [2:0][W:0]   as3_reg;
    logic              big3_reg;
    logic [2:0][W-1:0] a3_reg;
    logic [W-1:0]      s3_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            e_c[i] = {{2{p2_reg[i][PW-1]}}, p2_reg[i]};
        end
        if (op2_reg == OP_CROSS)
        begin
            c_c[0] = e_c[0] - e_c[3];
            c_c[1] = e_c[1] - e_c[4];
            c_c[2] = e_c[2] - e_c[5];
        end
        else if (op2_reg == OP_SCALE)
        begin
            c_c[0] = e_c[0];
            c_c[1] = e_c[1];
            c_c[2] = e_c[2];
        end
        else
        begin
            c_c[0] = e_c[0] + e_c[1] + e_c[2];
            c_c[1] = e_c[1];
            c_c[2] = e_c[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            op3_reg  <= op2_reg;
            c3_reg   <= c_c;
            as3_reg  <= as2_reg;
            big3_reg <= big2_reg;
            a3_reg   <= a2_reg;
            s3_reg   <= s2_reg;
        end
    end

    // stage 4
    logic               addsub_c;
    logic [2:0][CW-1:0] src_c;
    logic [2:0][CW-1:0] mag_c;
    logic [2:0]         neg_c;
    op_t                op4_reg;
    logic [2:0][CW-1:0] mag4_reg;
    logic [2:0]         neg4_reg;
    logic [PW-1:0]      rad4_reg;
    logic               big4_reg;
    logic [2:0][W-1:0]  a4_reg;
    logic [W-1:0]       s4_reg;

    always_comb
    begin
        addsub_c = (op3_reg == OP_ADD) || (op3_reg == OP_SUB);
        for (int i = 0; i < 3; i++)
        begin
            src_c[i] = addsub_c ? {{(CW-W-1){as3_reg[i][W]}}, as3_reg[i]} : c3_reg[i];
            neg_c[i] = src_c[i][CW-1];
            mag_c[i] = neg_c[i] ? (~src_c[i] + 1'b1) : src_c[i];
            if (!addsub_c)
            begin
                mag_c[i] = mag_c[i] >> FRAC_BITS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            op4_reg  <= op3_reg;
            mag4_reg <= mag_c;
            neg4_reg <= neg_c;
            rad4_reg <= c3_reg[0][PW-1:0];
            big4_reg <= big3_reg;
            a4_reg   <= a3_reg;
            s4_reg   <= s3_reg;
        end
    end

    // stage 5
    logic [2:0][W-1:0] satw_c;
    logic [2:0]        ovf_c;
    logic [2:0]        aneg_c;
    logic [2:0][W-1:0] amag_c;
    logic              sneg_c;
    logic [W-1:0]      smag_c;
    v3a_ctrl_t         ctrl_c;
    logic [3:0][W-1:0] word_c;
    logic [2:0]        qneg_c;

    v3a_ctrl_t         ctrl5_reg;
    logic [3:0][W-1:0] word5_reg;
    logic [2:0][W-1:0] num5_reg;
    logic [2:0]        qneg5_reg;
    logic [W-1:0]      sden5_reg;
    logic [PW-1:0]     rad5_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_sat
        v3a_sat #(.WORD_BITS(W), .MAG_BITS(CW)) u_sat
        (
            .neg  (neg4_reg[i]),
            .mag  (mag4_reg[i]),
            .word (satw_c[i]),
            .ovf  (ovf_c[i])
        );
    end

    always_comb
    begin
        sneg_c = s4_reg[W-1];
        smag_c = sneg_c ? (~s4_reg + 1'b1) : s4_reg;
        for (int i = 0; i < 3; i++)
        begin
            aneg_c[i] = a4_reg[i][W-1];
            amag_c[i] = aneg_c[i] ? (~a4_reg[i] + 1'b1) : a4_reg[i];
        end
        ctrl_c = '0;
        word_c = '0;
        qneg_c = aneg_c;
        unique case (op4_reg) inside
            OP_ADD, OP_SUB, OP_SCALE, OP_CROSS:
            begin
                word_c[2:0]  = satw_c;
                ctrl_c.fault = |ovf_c;
            end
            OP_DOT:
            begin
                word_c[3]    = satw_c[0];
                ctrl_c.fault = ovf_c[0];
            end
            OP_DIV:
            begin
                ctrl_c.den_s = 1'b1;
                if (s4_reg == '0)
                begin
                    ctrl_c.fault = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (a4_reg[i] != '0)
                        begin
                            word_c[i] = aneg_c[i] ? WMIN : WMAX;
                        end
                    end
                end
                else
                begin
                    ctrl_c.use_div = 1'b1;
                    qneg_c = aneg_c ^ {3{sneg_c}};
                end
            end
            OP_NORM:
            begin
                if (rad4_reg == '0)
                begin
                    word_c[2:0] = a4_reg;
                end
                else
                begin
                    ctrl_c.use_div = 1'b1;
                end
            end
            OP_MAG:
            begin
                ctrl_c.use_root = 1'b1;
            end
            OP_DIST:
            begin
                if (big4_reg)
                begin
                    ctrl_c.fault = 1'b1;
                    word_c[3]    = WMAX;
                end
                else
                begin
                    ctrl_c.use_root = 1'b1;
                end
            end
            default:
            begin
                word_c = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            ctrl5_reg <= ctrl_c;
            word5_reg <= word_c;
            num5_reg  <= amag_c;
            qneg5_reg <= qneg_c;
            sden5_reg <= smag_c;
            rad5_reg  <= rad4_reg;
        end
    end

    assign ctrl_out = ctrl5_reg;
    assign word_out = word5_reg;
    assign num_out  = num5_reg;
    assign qneg_out = qneg5_reg;
    assign sden_out = sden5_reg;
    assign rad_out  = rad5_reg;

endmodule

@@ rtl/v3a_sqrt_step.sv @@
// One square root stage: retire one root bit from two radicand bits.
module v3a_sqrt_step
#(
    parameter int WORD_BITS = 32,
    parameter int SIDE_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [2*WORD_BITS-1:0] rad_in,
    input  logic [WORD_BITS+1:0]   rem_in,
    input  logic [WORD_BITS-1:0]   root_in,
    input  logic [SIDE_BITS-1:0]   side_in,
    output logic [2*WORD_BITS-1:0] rad_out,
    output logic [WORD_BITS+1:0]   rem_out,
    output logic [WORD_BITS-1:0]   root_out,
    output logic [SIDE_BITS-1:0]   side_out
);

    localparam int W = WORD_BITS;

    logic [W+1:0]     rem_sh;
    logic [W+1:0]     trial;
    logic [W+1:0]     rem_c;
    logic [W-1:0]     root_c;
    logic [2*W-1:0]   rad_reg;
    logic [W+1:0]     rem_reg;
    logic [W-1:0]     root_reg;
    logic [SIDE_BITS-1:0] side_reg;

    always_comb
    begin
        rem_sh = {rem_in[W-1:0], rad_in[2*W-1 -: 2]};
        trial  = {root_in, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_c  = rem_sh - trial;
            root_c = {root_in[W-2:0], 1'b1};
        end
        else
        begin
            rem_c  = rem_sh;
            root_c = {root_in[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_in << 2;
            rem_reg  <= rem_c;
            root_reg <= root_c;
            side_reg <= side_in;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/v3a_div_step.sv @@
// One restoring divide stage for three lanes sharing a divisor.
module v3a_div_step
#(
    parameter int WORD_BITS = 32,
    parameter int NUM_BITS  = 48,
    parameter int SIDE_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [WORD_BITS-1:0]          den_in,
    input  logic [2:0][NUM_BITS-1:0]      num_in,
    input  logic [2:0][WORD_BITS-1:0]     rem_in,
    input  logic [2:0][NUM_BITS-1:0]      quo_in,
    input  logic [SIDE_BITS-1:0]          side_in,
    output logic [WORD_BITS-1:0]          den_out,
    output logic [2:0][NUM_BITS-1:0]      num_out,
    output logic [2:0][WORD_BITS-1:0]     rem_out,
    output logic [2:0][NUM_BITS-1:0]      quo_out,
    output logic [SIDE_BITS-1:0]          side_out
);

    localparam int W = WORD_BITS;

    logic [2:0][W:0]          rem_sh;
    logic [W:0]               den_x;
    logic [2:0][W-1:0]        rem_c;
    logic [2:0][NUM_BITS-1:0] quo_c;
    logic [W-1:0]             den_reg;
    logic [2:0][NUM_BITS-1:0] num_reg;
    logic [2:0][W-1:0]        rem_reg;
    logic [2:0][NUM_BITS-1:0] quo_reg;
    logic [SIDE_BITS-1:0]     side_reg;

    always_comb
    begin
        den_x = {1'b0, den_in};
        for (int i = 0; i < 3; i++)
        begin
            rem_sh[i] = {rem_in[i], num_in[i][NUM_BITS-1]};
            if (rem_sh[i] >= den_x)
            begin
                rem_c[i] = W'(rem_sh[i] - den_x);
                quo_c[i] = {quo_in[i][NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_c[i] = rem_sh[i][W-1:0];
                quo_c[i] = {quo_in[i][NUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= num_in[i] << 1;
            end
            rem_reg  <= rem_c;
            quo_reg  <= quo_c;
            side_reg <= side_in;
        end
    end

    assign den_out  = den_reg;
    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/v3a_checker.sv @@
// Port checker for vector3_alu and its bind.
`include "vector3_alu_macros.svh"

module v3a_checker
#(
    parameter int OUT_DATA_BITS = 128
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata,
    input logic                     m_tuser
);

    `V3A_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")
    `V3A_ASSERT(a_ready_pass, m_tready |-> s_tready, "input stalled while output side is ready")
    `V3A_ASSERT_RST(a_reset_idle, !rst_n |-> !m_tvalid, "result item shown during reset")

endmodule

bind vector3_alu v3a_checker #(.OUT_DATA_BITS(OUT_DATA)) u_v3a_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
